/* hdl/iopd_pkg.sv */
// I/O port decoder package: event and result transfer types, port decode constants.
// No dependencies.

package iopd_pkg;

  localparam int unsigned VRAM_DEPTH_DEF = 8192;
  localparam int unsigned KEY_ROWS_DEF   = 10;

  localparam logic [15:0] REGION_MASK = 16'hE000;
  localparam logic [15:0] REGION_VRAM = 16'h0000;
  localparam logic [15:0] REGION_MODE = 16'h2000;
  localparam logic [15:0] REGION_PSG  = 16'h4000;
  localparam logic [15:0] REGION_CAS  = 16'h6000;
  localparam logic [15:0] REGION_BOOT = 16'hA000;
  localparam logic [15:0] PSG_MASK    = 16'hFFFE;
  localparam logic [11:0] KBD_PAGE    = 12'h800;

  localparam logic [7:0] PSG_CAS_REG   = 8'd14;
  localparam logic [7:0] KEY_ROW_RESET = 8'hFF;
  localparam logic [7:0] MODE_RESET    = 8'h00;

  typedef enum logic [1:0] {
    EV_IO_WR  = 2'd0,
    EV_IO_RD  = 2'd1,
    EV_KEY_DN = 2'd2,
    EV_KEY_UP = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    REQ_NONE    = 3'd0,
    REQ_CAS_WR  = 3'd1,
    REQ_PSG_WR  = 3'd2,
    REQ_PSG_SEL = 3'd3,
    REQ_CAS_RD  = 3'd4,
    REQ_PSG_RD  = 3'd5
  } req_e;

  typedef struct packed {
    event_e      mode;
    logic [15:0] port;
    logic [7:0]  wdata;
    logic [3:0]  key_row;
    logic [7:0]  key_mask;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    req_e       ext_request;
    logic [7:0] ext_data;
    logic [7:0] psg_register;
    logic       boot_rom_mapped;
    logic [7:0] video_mode;
    logic       video_mode_changed;
  } result_t;

endpackage

/* hdl/io_port_decoder.sv */
// I/O port decoder top level: event decode, video RAM and keyboard row storage.
// Depends on iopd_pkg and iopd_ram.
//
// One event is taken when start is high and busy is low; its result appears on
// result_o with done_o high for one cycle, registered from the read-modify-write
// stage (s1_q). The video RAM and keyboard-row RAM reads are registered, and the
// read-modify-write completes in the s1_q stage, with busy high, so no new event
// is taken before it completes. The receiver cannot stall; result_o is valid only
// while done_o is high. After reset the video RAM is zeroed one entry per cycle,
// all VRAM_DEPTH entries (8192 by default), with busy held high.

module io_port_decoder import iopd_pkg::*; #(
  parameter int unsigned VRAM_DEPTH = VRAM_DEPTH_DEF,
  parameter int unsigned KEY_ROWS   = KEY_ROWS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  localparam int unsigned VA = $clog2(VRAM_DEPTH);
  localparam int unsigned KA = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;

  logic          s1_q;
  item_t         item_q;
  logic [VA-1:0] vaddr_q, vaddr_d;
  logic [KA-1:0] kaddr_q, kaddr_d;
  logic          clr_q;
  logic [VA-1:0] clr_cnt_q;
  logic          boot_q, boot_d;
  logic [7:0]    mode_q, mode_d;
  logic [7:0]    psg_q, psg_d;
  logic [KEY_ROWS-1:0] kvld_q, kvld_d;
  logic          done_q;
  result_t       result_q, result_d;

  logic          accept;
  logic [15:0]   vrem;
  logic          vram_we_s1, vram_we;
  logic [VA-1:0] vram_waddr;
  logic [7:0]    vram_wdata, vram_rdata;
  logic          key_we;
  logic [7:0]    key_wdata, key_rdata, key_cur;
  logic [15:0]   region;
  logic          kbd_hit, row_ok;

  assign busy   = clr_q | s1_q;
  assign accept = start & ~busy;

  // port modulo VRAM_DEPTH: region 0 port is below 8 * VRAM_DEPTH
  always_comb begin
    vrem = {3'b000, item_i.port[12:0]};
    for (int k = 2; k >= 0; k--) begin
      if (vrem >= 16'(VRAM_DEPTH << k)) begin
        vrem = vrem - 16'(VRAM_DEPTH << k);
      end
    end
    vaddr_d = vrem[VA-1:0];
    kaddr_d = (item_i.mode == EV_IO_RD) ? item_i.port[KA-1:0] : item_i.key_row[KA-1:0];
  end

  assign vram_we    = clr_q | vram_we_s1;
  assign vram_waddr = clr_q ? clr_cnt_q : vaddr_q;
  assign vram_wdata = clr_q ? 8'h00 : item_q.wdata;

  iopd_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (vaddr_d),
    .rdata_o (vram_rdata)
  );

  iopd_ram #(.WIDTH(8), .DEPTH(KEY_ROWS)) u_krow (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (kaddr_q),
    .wdata_i (key_wdata),
    .raddr_i (kaddr_d),
    .rdata_o (key_rdata)
  );

  assign key_cur = kvld_q[kaddr_q] ? key_rdata : KEY_ROW_RESET;
  assign region  = item_q.port & REGION_MASK;
  assign kbd_hit = (item_q.port[15:4] == KBD_PAGE) && ({1'b0, item_q.port[3:0]} < 5'(KEY_ROWS));
  assign row_ok  = {1'b0, item_q.key_row} < 5'(KEY_ROWS);

  always_comb begin
    boot_d     = boot_q;
    mode_d     = mode_q;
    psg_d      = psg_q;
    kvld_d     = kvld_q;
    vram_we_s1 = 1'b0;
    key_we     = 1'b0;
    key_wdata  = key_cur;
    result_d   = '0;
    result_d.ext_request = REQ_NONE;
    if (s1_q) begin
      unique case (item_q.mode)
        EV_IO_WR: begin
          if (region == REGION_VRAM) begin
            vram_we_s1 = 1'b1;
          end else if (region == REGION_BOOT) begin
            boot_d = ~boot_q;
          end else if (region == REGION_MODE) begin
            result_d.video_mode_changed = (mode_q != item_q.wdata);
            mode_d = item_q.wdata;
          end else if (region == REGION_CAS) begin
            result_d.ext_request = REQ_CAS_WR;
            result_d.ext_data    = item_q.wdata;
          end else if ((item_q.port & PSG_MASK) == REGION_PSG) begin
            if (item_q.port[0]) begin
              result_d.ext_request = REQ_PSG_WR;
            end else begin
              result_d.ext_request = REQ_PSG_SEL;
              psg_d = item_q.wdata;
            end
            result_d.ext_data = item_q.wdata;
          end
        end
        EV_IO_RD: begin
          if (kbd_hit) begin
            result_d.read_data = key_cur;
          end else if (region == REGION_BOOT) begin
            boot_d = ~boot_q;
          end else if (region == REGION_MODE) begin
            result_d.read_data = mode_q;
          end else if (region == REGION_VRAM) begin
            result_d.read_data = vram_rdata;
          end else if ((item_q.port & PSG_MASK) == REGION_PSG) begin
            if (item_q.port[0]) begin
              result_d.ext_request = (psg_q == PSG_CAS_REG) ? REQ_CAS_RD : REQ_PSG_RD;
            end
          end
        end
        EV_KEY_DN: begin
          key_wdata = key_cur & ~item_q.key_mask;
          if (row_ok) begin
            key_we = 1'b1;
            kvld_d[kaddr_q] = 1'b1;
          end
        end
        EV_KEY_UP: begin
          key_wdata = key_cur | item_q.key_mask;
          if (row_ok) begin
            key_we = 1'b1;
            kvld_d[kaddr_q] = 1'b1;
          end
        end
        default: ;
      endcase
    end
    result_d.psg_register    = psg_d;
    result_d.boot_rom_mapped = boot_d;
    result_d.video_mode      = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      boot_q    <= 1'b1;
      mode_q    <= MODE_RESET;
      psg_q     <= 8'h00;
      kvld_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      s1_q   <= accept;
      done_q <= s1_q;
      boot_q <= boot_d;
      mode_q <= mode_d;
      psg_q  <= psg_d;
      kvld_q <= kvld_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + VA'(1);
        if (clr_cnt_q == VA'(VRAM_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= item_i;
      vaddr_q <= vaddr_d;
      kaddr_q <= kaddr_d;
    end
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> busy)
    else $error("event transfer possible during video RAM clear");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |=> !s1_q)
    else $error("second event entered before read-modify-write completed");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |=> done_q)
    else $error("result strobe missing after event");
  a_no_clear_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |-> !clr_q)
    else $error("event write collides with clear pass");
  a_changed_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q && item_q.mode != EV_IO_WR |=> !result_q.video_mode_changed)
    else $error("mode change flagged on non-write event");
`endif

endmodule

/* hdl/iopd_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.

module iopd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
